@@ rtl/rhc_pkg.sv @@
// Shared types and constants for the RGB to HSV/HSL/CMYK converter.
// No dependencies.
package rhc_pkg;

   typedef logic [1:0] mode_type;

   localparam mode_type MODE_HSV  = 2'd0;
   localparam mode_type MODE_HSL  = 2'd1;
   localparam mode_type MODE_CMYK = 2'd2;

   localparam int DEG_SECTOR = 60;
   localparam int DEG_FULL   = 360;
   localparam int CHAN_MAX   = 255;

   typedef struct packed {
      mode_type    mode;
      logic        dzero;
      logic        mzero;
      logic [7:0]  peak;
      logic [15:0] alpha;
   } side_type;

endpackage

@@ rtl/rhc_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; used by rgb_to_hsv_hsl_cmyk_converter_core.
module rhc_div #(
   parameter int NW = 26,
   parameter int DW = 10,
   parameter int QW = 17
) (
   input  logic          clock,
   input  logic [NW-1:0] num_i,
   input  logic [DW-1:0] den_i,
   output logic [QW-1:0] quo_o
);

   logic [DW-1:0] rem_ff [NW];
   logic [NW-1:0] nrest_ff [NW];
   logic [DW-1:0] den_ff [NW];
   logic [QW-1:0] quo_ff [NW];

   for (genvar k = 0; k < NW; k++) begin : g_stage
      logic [DW-1:0] rp;
      logic [NW-1:0] np;
      logic [DW-1:0] dp;
      logic [QW-1:0] qp;
      logic [DW:0]   trial;
      logic          ge;
      logic [DW:0]   diff;
      logic [DW-1:0] rem_in;
      logic [NW-1:0] nrest_in;
      logic [QW-1:0] quo_in;

      if (k == 0) begin : g_first
         assign rp = '0;
         assign np = num_i;
         assign dp = den_i;
         assign qp = '0;
      end else begin : g_next
         assign rp = rem_ff[k-1];
         assign np = nrest_ff[k-1];
         assign dp = den_ff[k-1];
         assign qp = quo_ff[k-1];
      end

      always_comb begin
         trial    = {rp, np[NW-1]};
         ge       = (trial >= {1'b0, dp});
         diff     = trial - {1'b0, dp};
         rem_in   = ge ? diff[DW-1:0] : trial[DW-1:0];
         nrest_in = {np[NW-2:0], 1'b0};
         quo_in   = {qp[QW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         rem_ff[k]   <= rem_in;
         nrest_ff[k] <= nrest_in;
         den_ff[k]   <= dp;
         quo_ff[k]   <= quo_in;
      end
   end

   assign quo_o = quo_ff[NW-1];

endmodule

@@ rtl/rgb_to_hsv_hsl_cmyk_converter_core.sv @@
// Top level of the RGB to HSV/HSL/CMYK converter.
// Depends on rhc_pkg and rhc_div.
//
// Channel   Direction  Handshake            Payload
// request   in         start / busy         req_red, req_green, req_blue, req_alpha_in
// response  out        rsp_valid (strobe)   rsp_*_component, rsp_alpha_out
// csr       in         csr_valid/csr_ready  csr_data (conversion mode)
//
// One pixel is accepted every cycle; busy is always low.
// The pipeline has one setup stage, FRACTION_BITS + 10 divider stages of one
// quotient bit each, and one output stage.
// Synchronous reset clears the valid bits and the mode register.
// The receiver cannot stall, so the pipeline never holds.
module rgb_to_hsv_hsl_cmyk_converter_core #(
   parameter int FRACTION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [15:0] req_alpha_in,
   output logic        rsp_valid,
   output logic [15:0] rsp_first_component,
   output logic [15:0] rsp_second_component,
   output logic [15:0] rsp_third_component,
   output logic [15:0] rsp_fourth_component,
   output logic [15:0] rsp_alpha_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_data
);

   localparam int FB = FRACTION_BITS;
   localparam int NW = FB + 10;
   localparam int DW = 10;
   localparam int QW = FB + 1;
   localparam logic [QW-1:0] FULL = QW'((64'd1 << FB) - 64'd1);
   localparam logic [QW-1:0] WRAP = QW'(rhc_pkg::DEG_FULL);
   localparam logic [QW-1:0] KEY_A = QW'(((64'd1 << FB) - 64'd1) / 64'd255);
   localparam logic [15:0]   KEY_B = 16'(((64'd1 << FB) - 64'd1) % 64'd255);

   rhc_pkg::mode_type mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= rhc_pkg::MODE_HSV;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= csr_data;
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   function automatic logic [NW-1:0] frac_num(input logic [9:0] n, input logic [9:0] d);
      logic [NW-1:0] nw;
      nw = NW'(n);
      return (nw << (FB + 1)) - (nw << 1) + NW'(d);
   endfunction

   logic [7:0]  mx, mn, dl;
   logic [8:0]  sm, lden;
   logic [17:0] hnum, hn;
   logic [17:0] d60, d120, d240, d360;
   logic [17:0] m_rg, m_gb, m_br;
   logic [NW-1:0] n_in [3];
   logic [DW-1:0] d_in [3];
   rhc_pkg::side_type side_in;

   always_comb begin
      mx = req_red;
      if (req_green > mx) mx = req_green;
      if (req_blue > mx) mx = req_blue;
      mn = req_red;
      if (req_green < mn) mn = req_green;
      if (req_blue < mn) mn = req_blue;
      dl = mx - mn;
      sm = 9'(mx) + 9'(mn);
      lden = (sm <= 9'(rhc_pkg::CHAN_MAX)) ? sm : 9'(2 * rhc_pkg::CHAN_MAX) - sm;

      d60  = 18'(dl) * 18'(rhc_pkg::DEG_SECTOR);
      d120 = d60 << 1;
      d240 = d60 << 2;
      d360 = 18'(dl) * 18'(rhc_pkg::DEG_FULL);
      m_gb = (req_green >= req_blue) ? 18'(req_green - req_blue) : 18'(req_blue - req_green);
      m_br = (req_blue >= req_red) ? 18'(req_blue - req_red) : 18'(req_red - req_blue);
      m_rg = (req_red >= req_green) ? 18'(req_red - req_green) : 18'(req_green - req_red);
      m_gb = m_gb * 18'(rhc_pkg::DEG_SECTOR);
      m_br = m_br * 18'(rhc_pkg::DEG_SECTOR);
      m_rg = m_rg * 18'(rhc_pkg::DEG_SECTOR);

      if (mx == req_red) begin
         hnum = (req_green >= req_blue) ? m_gb : d360 - m_gb;
      end else if (mx == req_green) begin
         hnum = (req_blue >= req_red) ? d120 + m_br : d120 - m_br;
      end else begin
         hnum = (req_red >= req_green) ? d240 + m_rg : d240 - m_rg;
      end
      hn = (hnum << 1) + 18'(dl);

      case (mode_ff)
         rhc_pkg::MODE_CMYK: begin
            n_in[0] = frac_num(10'(mx - req_red), 10'(mx));
            n_in[1] = frac_num(10'(mx - req_green), 10'(mx));
            n_in[2] = frac_num(10'(mx - req_blue), 10'(mx));
            d_in[0] = {1'b0, mx, 1'b0};
            d_in[1] = {1'b0, mx, 1'b0};
            d_in[2] = {1'b0, mx, 1'b0};
         end
         rhc_pkg::MODE_HSL: begin
            n_in[0] = NW'(hn);
            n_in[1] = frac_num(10'(dl), 10'(lden));
            n_in[2] = frac_num(10'(sm), 10'(2 * rhc_pkg::CHAN_MAX));
            d_in[0] = {1'b0, dl, 1'b0};
            d_in[1] = {lden, 1'b0};
            d_in[2] = DW'(4 * rhc_pkg::CHAN_MAX);
         end
         default: begin
            n_in[0] = NW'(hn);
            n_in[1] = frac_num(10'(dl), 10'(mx));
            n_in[2] = frac_num(10'(mx), 10'(rhc_pkg::CHAN_MAX));
            d_in[0] = {1'b0, dl, 1'b0};
            d_in[1] = {1'b0, mx, 1'b0};
            d_in[2] = DW'(2 * rhc_pkg::CHAN_MAX);
         end
      endcase

      side_in.mode  = mode_ff;
      side_in.dzero = (dl == 8'd0);
      side_in.mzero = (mx == 8'd0);
      side_in.peak  = mx;
      side_in.alpha = req_alpha_in;
   end

   logic          v0_ff;
   rhc_pkg::side_type s0_ff;
   logic [NW-1:0] n0_ff [3];
   logic [DW-1:0] d0_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      s0_ff <= side_in;
      n0_ff <= n_in;
      d0_ff <= d_in;
   end

   logic [QW-1:0] quo [3];

   for (genvar u = 0; u < 3; u++) begin : g_div
      rhc_div #(.NW(NW), .DW(DW), .QW(QW)) u_div (
         .clock (clock),
         .num_i (n0_ff[u]),
         .den_i (d0_ff[u]),
         .quo_o (quo[u])
      );
   end

   logic              vld_ff  [NW];
   rhc_pkg::side_type side_ff [NW];

   for (genvar k = 0; k < NW; k++) begin : g_side
      logic              vp;
      rhc_pkg::side_type sp;
      if (k == 0) begin : g_first
         assign vp = v0_ff;
         assign sp = s0_ff;
      end else begin : g_next
         assign vp = vld_ff[k-1];
         assign sp = side_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vp;
         end
      end
      always_ff @(posedge clock) begin
         side_ff[k] <= sp;
      end
   end

   function automatic logic [15:0] low16(input logic [QW-1:0] v);
      logic [QW+15:0] w;
      w = {16'd0, v};
      return w[15:0];
   endfunction

   function automatic logic [15:0] sat16(input logic [QW-1:0] v);
      return low16((v > FULL) ? FULL : v);
   endfunction

   rhc_pkg::side_type st;
   logic [QW-1:0] hue;
   logic [7:0]    kn;
   logic [15:0]   kr;
   logic [16:0]   ks;
   logic [8:0]    kq;
   logic [QW-1:0] key;
   logic [15:0] c1_in, c2_in, c3_in, c4_in;
   logic        valid_in;

   // The key is (255 - max) * FULL / 255, split as n * (FULL / 255) plus a
   // rounded n * (FULL % 255) / 255 that is small enough for a shift-add divide.
   always_comb begin
      st  = side_ff[NW-1];
      hue = (quo[0] >= WRAP) ? quo[0] - WRAP : quo[0];
      kn  = 8'(rhc_pkg::CHAN_MAX) - st.peak;
      kr  = 16'(kn) * KEY_B + 16'd127;
      ks  = 17'(kr) + 17'd1 + 17'(kr[15:8]);
      kq  = ks[16:8];
      key = QW'(kn) * KEY_A + QW'(kq);
      valid_in = vld_ff[NW-1];
      c1_in = '0;
      c2_in = '0;
      c3_in = '0;
      c4_in = '0;
      case (st.mode)
         rhc_pkg::MODE_HSV: begin
            c3_in = sat16(quo[2]);
            if (!st.dzero) begin
               c1_in = low16(hue);
               c2_in = sat16(quo[1]);
            end
         end
         rhc_pkg::MODE_HSL: begin
            c3_in = sat16(quo[2]);
            if (!st.dzero) begin
               c1_in = low16(hue);
               c2_in = sat16(quo[1]);
            end
         end
         rhc_pkg::MODE_CMYK: begin
            if (st.mzero) begin
               c4_in = low16(FULL);
            end else begin
               c1_in = sat16(quo[0]);
               c2_in = sat16(quo[1]);
               c3_in = sat16(quo[2]);
               c4_in = sat16(key);
            end
         end
         default: begin
            c1_in = '0;
         end
      endcase
   end

   logic        out_valid_ff;
   logic [15:0] c1_ff, c2_ff, c3_ff, c4_ff, alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      c1_ff    <= c1_in;
      c2_ff    <= c2_in;
      c3_ff    <= c3_in;
      c4_ff    <= c4_in;
      alpha_ff <= st.alpha;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_first_component  = c1_ff;
   assign rsp_second_component = c2_ff;
   assign rsp_third_component  = c3_ff;
   assign rsp_fourth_component = c4_ff;
   assign rsp_alpha_out        = alpha_ff;

endmodule
